// ===== sv/skt_pkg.sv =====
// Shared types for the sorted key table: operation and status codes, the
// controller state type, and the command and status structs between
// controller and datapath. No dependencies.
`default_nettype none

package skt_pkg;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_MISSING = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SEARCH_RD,
    S_SEARCH_CMP,
    S_CHECK_RD,
    S_CHECK_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_PUT,
    S_RESP
  } ctl_state_t;

  typedef struct packed {
    logic    start;
    logic    cnt_clr;
    logic    probe;
    logic    step_lb;
    logic    step_lu;
    logic    check_rd;
    logic    shift_up;
    logic    shift_rd;
    logic    shift_wr;
    logic    put;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    load_out;
    logic    out_found;
    status_t out_status;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic key_top;
    logic range_open;
    logic lo_lt_count;
    logic more_up;
    logic more_down;
    logic less;
    logic equal;
  } sts_t;

endpackage

`default_nettype wire

// ===== sv/skt_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module skt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== sv/skt_datapath.sv =====
// Datapath of the sorted key table: entry RAM, search bounds, shift pointer,
// entry count and result registers. Depends on skt_pkg and skt_ram.
`default_nettype none

module skt_datapath #(
  parameter int CAPACITY = 256
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic [31:0]     in_key,
  input  wire logic [31:0]     in_value,
  input  wire skt_pkg::cmd_t   cmd,
  output skt_pkg::sts_t        sts,
  output skt_pkg::status_t     status,
  output logic [7:0]           found_index,
  output logic [31:0]          found_value,
  output logic [8:0]           entries_held
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);

  logic [31:0]   key_r;
  logic [31:0]   value_r;
  logic [CW-1:0] lo;
  logic [CW-1:0] hi1;
  logic [CW-1:0] ptr;
  logic [CW-1:0] count;
  logic [AW-1:0] hit_index;
  logic [31:0]   hit_value;

  logic [CW:0]   mid_sum;
  logic [AW-1:0] mid;
  logic [CW-1:0] ptr_dn;
  logic [CW-1:0] ptr_up;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [63:0]   ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [63:0]   ram_rdata;

  // Probe point of the half-open range [lo, hi1).
  assign mid_sum = {1'b0, lo} + {1'b0, hi1} - (CW + 1)'(1);
  assign mid     = mid_sum[AW:1];
  assign ptr_dn  = ptr - CW'(1);
  assign ptr_up  = ptr + CW'(1);

  assign sts.full        = (count == CW'(CAPACITY));
  assign sts.key_top     = key_r[31];
  assign sts.range_open  = (lo < hi1);
  assign sts.lo_lt_count = (lo < count);
  assign sts.more_up     = (ptr > lo);
  assign sts.more_down   = ({1'b0, ptr} + (CW + 1)'(1)) < {1'b0, count};
  assign sts.less        = (ram_rdata[31:0] < key_r);
  assign sts.equal       = (ram_rdata[31:0] == key_r);

  always_comb begin
    ram_re = cmd.probe | cmd.check_rd | cmd.shift_rd;
    priority if (cmd.probe) begin
      ram_raddr = mid;
    end else if (cmd.check_rd) begin
      ram_raddr = AW'(lo);
    end else if (cmd.shift_up) begin
      ram_raddr = AW'(ptr_dn);
    end else begin
      ram_raddr = AW'(ptr_up);
    end
    ram_we    = cmd.shift_wr | cmd.put;
    ram_waddr = cmd.put ? AW'(lo) : AW'(ptr);
    ram_wdata = cmd.put ? {value_r, key_r} : ram_rdata;
  end

  skt_ram #(
    .WIDTH(64),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.cnt_clr) begin
      count <= '0;
    end else if (cmd.cnt_inc) begin
      count <= count + CW'(1);
    end else if (cmd.cnt_dec) begin
      count <= count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      key_r   <= in_key;
      value_r <= in_value;
      lo      <= '0;
      hi1     <= count;
      ptr     <= count;
    end
    if (cmd.step_lb) begin
      if (sts.less) begin
        lo <= CW'(mid) + CW'(1);
      end else begin
        hi1 <= CW'(mid);
      end
    end
    if (cmd.step_lu) begin
      if (sts.less) begin
        lo <= CW'(mid) + CW'(1);
      end else if (!sts.equal) begin
        hi1 <= CW'(mid);
      end else begin
        hit_index <= mid;
        hit_value <= ram_rdata[63:32];
      end
    end
    if (cmd.check_rd) begin
      ptr <= lo;
    end
    if (cmd.shift_wr) begin
      ptr <= cmd.shift_up ? ptr_dn : ptr_up;
    end
    if (cmd.load_out) begin
      status       <= cmd.out_status;
      found_index  <= cmd.out_found ? 8'(hit_index) : 8'd0;
      found_value  <= cmd.out_found ? hit_value : 32'd0;
      entries_held <= 9'(count);
    end
  end

  a_put_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.put |-> (lo <= count) && !sts.full)
    else $error("new entry written outside the occupied range");

  a_inc_not_full: assert property (@(posedge clk) disable iff (rst)
    cmd.cnt_inc |=> (count <= CW'(CAPACITY)) && (count != '0))
    else $error("entry count overflowed");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

endmodule

`default_nettype wire

// ===== sv/skt_controller.sv =====
// Controller of the sorted key table: sequences search, shift and write
// steps and owns the handshake of both channels. Depends on skt_pkg.
`default_nettype none

module skt_controller (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_tvalid,
  input  wire skt_pkg::op_t  s_func,
  output logic               s_tready,
  output logic               m_tvalid,
  input  wire logic          m_tready,
  output skt_pkg::cmd_t      cmd,
  input  wire skt_pkg::sts_t sts
);

  skt_pkg::ctl_state_t state;
  skt_pkg::ctl_state_t state_next;
  skt_pkg::op_t        op;
  skt_pkg::op_t        op_next;
  skt_pkg::status_t    resp_status;
  skt_pkg::status_t    resp_status_next;
  logic                resp_found;
  logic                resp_found_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= skt_pkg::S_IDLE;
      op          <= skt_pkg::OP_CLEAR;
      resp_status <= skt_pkg::ST_OK;
      resp_found  <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      state       <= state_next;
      op          <= op_next;
      resp_status <= resp_status_next;
      resp_found  <= resp_found_next;
      if (cmd.load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next       = state;
    op_next          = op;
    resp_status_next = resp_status;
    resp_found_next  = resp_found;
    cmd              = '0;
    cmd.shift_up     = (op == skt_pkg::OP_INSERT);
    s_tready         = (state == skt_pkg::S_IDLE);

    unique case (state)
      skt_pkg::S_IDLE: begin
        if (s_tvalid) begin
          cmd.start       = 1'b1;
          op_next         = s_func;
          resp_found_next = 1'b0;
          unique case (s_func)
            skt_pkg::OP_INSERT: begin
              if (sts.full) begin
                resp_status_next = skt_pkg::ST_FULL;
                state_next       = skt_pkg::S_RESP;
              end else begin
                state_next = skt_pkg::S_SEARCH_RD;
              end
            end
            skt_pkg::OP_REMOVE, skt_pkg::OP_LOOKUP: begin
              state_next = skt_pkg::S_SEARCH_RD;
            end
            skt_pkg::OP_CLEAR: begin
              cmd.cnt_clr      = 1'b1;
              resp_status_next = skt_pkg::ST_OK;
              state_next       = skt_pkg::S_RESP;
            end
          endcase
        end
      end
      skt_pkg::S_SEARCH_RD: begin
        priority if (op == skt_pkg::OP_LOOKUP && sts.key_top) begin
          resp_status_next = skt_pkg::ST_MISSING;
          state_next       = skt_pkg::S_RESP;
        end else if (sts.range_open) begin
          cmd.probe  = 1'b1;
          state_next = skt_pkg::S_SEARCH_CMP;
        end else if (op == skt_pkg::OP_INSERT) begin
          state_next = skt_pkg::S_SHIFT_RD;
        end else if (op == skt_pkg::OP_REMOVE) begin
          state_next = skt_pkg::S_CHECK_RD;
        end else begin
          resp_status_next = skt_pkg::ST_MISSING;
          state_next       = skt_pkg::S_RESP;
        end
      end
      skt_pkg::S_SEARCH_CMP: begin
        if (op == skt_pkg::OP_LOOKUP) begin
          cmd.step_lu = 1'b1;
          if (sts.equal) begin
            resp_status_next = skt_pkg::ST_OK;
            resp_found_next  = 1'b1;
            state_next       = skt_pkg::S_RESP;
          end else begin
            state_next = skt_pkg::S_SEARCH_RD;
          end
        end else begin
          cmd.step_lb = 1'b1;
          state_next  = skt_pkg::S_SEARCH_RD;
        end
      end
      skt_pkg::S_CHECK_RD: begin
        if (sts.lo_lt_count) begin
          cmd.check_rd = 1'b1;
          state_next   = skt_pkg::S_CHECK_CMP;
        end else begin
          resp_status_next = skt_pkg::ST_MISSING;
          state_next       = skt_pkg::S_RESP;
        end
      end
      skt_pkg::S_CHECK_CMP: begin
        if (sts.equal) begin
          state_next = skt_pkg::S_SHIFT_RD;
        end else begin
          resp_status_next = skt_pkg::ST_MISSING;
          state_next       = skt_pkg::S_RESP;
        end
      end
      skt_pkg::S_SHIFT_RD: begin
        priority if (op == skt_pkg::OP_INSERT && sts.more_up) begin
          cmd.shift_rd = 1'b1;
          state_next   = skt_pkg::S_SHIFT_WR;
        end else if (op == skt_pkg::OP_INSERT) begin
          state_next = skt_pkg::S_PUT;
        end else if (sts.more_down) begin
          cmd.shift_rd = 1'b1;
          state_next   = skt_pkg::S_SHIFT_WR;
        end else begin
          cmd.cnt_dec      = 1'b1;
          resp_status_next = skt_pkg::ST_OK;
          state_next       = skt_pkg::S_RESP;
        end
      end
      skt_pkg::S_SHIFT_WR: begin
        cmd.shift_wr = 1'b1;
        state_next   = skt_pkg::S_SHIFT_RD;
      end
      skt_pkg::S_PUT: begin
        cmd.put          = 1'b1;
        cmd.cnt_inc      = 1'b1;
        resp_status_next = skt_pkg::ST_OK;
        state_next       = skt_pkg::S_RESP;
      end
      skt_pkg::S_RESP: begin
        if (!m_tvalid || m_tready) begin
          cmd.load_out   = 1'b1;
          cmd.out_status = resp_status;
          cmd.out_found  = resp_found;
          state_next     = skt_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = skt_pkg::S_IDLE;
      end
    endcase
  end

  a_load_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!m_tvalid || m_tready))
    else $error("result register overwritten before it was taken");

  a_write_after_read: assert property (@(posedge clk) disable iff (rst)
    cmd.shift_wr |-> $past(cmd.shift_rd))
    else $error("shift write without a preceding read");

  a_full_drop: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_func == skt_pkg::OP_INSERT && sts.full)
      |=> (state == skt_pkg::S_RESP) && (resp_status == skt_pkg::ST_FULL))
    else $error("insert into a full table not dropped");

endmodule

`default_nettype wire

// ===== sv/sorted_key_table_core.sv =====
// Sorted key table: up to CAPACITY key/value pairs kept in ascending key
// order, with insert, remove, lookup and clear operations.
// Depends on skt_pkg, skt_controller and skt_datapath.
//
// Usage: each transaction on the s_ side carries one operation; exactly one
// result transaction follows on the m_ side, in order. Operations are taken
// one at a time: s_tready is high only while the controller is idle, but a
// new operation is accepted while the previous result still waits in the
// output register.
// Each search probe is a RAM read followed by a compare. Each moved entry
// takes a read and a write on the entry RAM, which has a single read and a
// single write port.
// Reset empties the table at once; no clearing pass is needed. When the
// receiver stalls, the result holds in the output register and the next
// operation finishes its work, then waits until that result is taken.
`default_nettype none

module sorted_key_table_core #(
  parameter int CAPACITY = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // func [1:0], entry_key [33:2], entry_value [65:34], zero [71:66]
  input  wire logic [71:0] s_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // status [1:0], found_index [9:2], found_value [41:10],
  // entries_held [50:42], zero [55:51]
  output logic      [55:0] m_tdata
);

  skt_pkg::cmd_t    cmd;
  skt_pkg::sts_t    sts;
  skt_pkg::status_t status;
  logic [7:0]       found_index;
  logic [31:0]      found_value;
  logic [8:0]       entries_held;

  skt_controller u_ctl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_func  (skt_pkg::op_t'(s_tdata[1:0])),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .cmd     (cmd),
    .sts     (sts)
  );

  skt_datapath #(
    .CAPACITY(CAPACITY)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .in_key      (s_tdata[33:2]),
    .in_value    (s_tdata[65:34]),
    .cmd         (cmd),
    .sts         (sts),
    .status      (status),
    .found_index (found_index),
    .found_value (found_value),
    .entries_held(entries_held)
  );

  assign m_tdata = {5'd0, entries_held, found_value, found_index, status};

endmodule

`default_nettype wire
